// ===== design/lsbr_pkg.sv =====
// lsbr_pkg: shared types, command codes and buffer geometry for the LSB-first bit reader.
// No dependencies; used by lsbr_banks and lsb_first_bit_reader.

package lsbr_pkg;

    // Buffer geometry: four byte-wide banks, byte index mod 4 selects the bank
    localparam int BUFFER_DEPTH = 4096;
    localparam int NUM_BANKS    = 4;
    localparam int BANK_ROWS    = BUFFER_DEPTH / NUM_BANKS;
    localparam int ROW_W        = $clog2(BANK_ROWS);

    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 16;
    localparam int OFF_W    = 3;
    localparam int LEN_W    = 13;
    localparam int IDX_W    = POS_W + 1;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(WORD_W);
    localparam logic [POS_W-1:0]   POS_MAX    = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 3'd0,
        CMD_RESTART = 3'd1,
        CMD_EXTRACT = 3'd2,
        CMD_PEEK    = 3'd3,
        CMD_ALIGN   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  address;
        logic [BYTE_W-1:0]  byte_value;
        logic [COUNT_W-1:0] bit_count;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] bits;
        logic [POS_W-1:0]  position;
        logic [OFF_W-1:0]  bit_offset;
    } out_beat_t;

    // Request from the control FSM to the bank array
    typedef struct packed {
        logic               rd_en;
        logic [POS_W-1:0]   rd_pos;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0]  wr_data;
    } bank_req_t;

endpackage

// ===== design/lsbr_ram.sv =====
// lsbr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module lsbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

// ===== design/lsbr_banks.sv =====
// lsbr_banks: four interleaved byte banks; fetches the 4-byte window at a byte position.
// Depends on lsbr_pkg and lsbr_ram.

module lsbr_banks (
    input  logic                          aclk,
    input  lsbr_pkg::bank_req_t           req,
    input  logic [lsbr_pkg::LEN_W-1:0]    data_length,
    output logic [lsbr_pkg::WORD_W-1:0]   word
);

    logic [1:0]                     phase;
    logic [1:0]                     phase_reg;
    logic [3:0]                     lane_valid;
    logic [3:0]                     lane_valid_reg;
    logic [lsbr_pkg::ROW_W-1:0]     base_row;
    logic [lsbr_pkg::POS_W-1:0]     wr_idx;
    logic [lsbr_pkg::BYTE_W-1:0]    rd_data [lsbr_pkg::NUM_BANKS];

    assign phase    = req.rd_pos[1:0];
    assign base_row = req.rd_pos[lsbr_pkg::ROW_W+1:2];
    assign wr_idx   = lsbr_pkg::POS_W'(req.wr_addr);

    // past data_length or past the buffer reads as zero
    always_comb begin
        logic [lsbr_pkg::IDX_W-1:0] idx;
        for (int i = 0; i < lsbr_pkg::NUM_BANKS; i++) begin
            idx = lsbr_pkg::IDX_W'(req.rd_pos) + lsbr_pkg::IDX_W'(i);
            lane_valid[i] = (idx < lsbr_pkg::IDX_W'(data_length)) &&
                            (idx < lsbr_pkg::IDX_W'(lsbr_pkg::BUFFER_DEPTH));
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            phase_reg      <= phase;
            lane_valid_reg <= lane_valid;
        end
    end

    for (genvar b = 0; b < lsbr_pkg::NUM_BANKS; b++) begin : g_bank
        logic [lsbr_pkg::ROW_W-1:0] rd_row;
        logic                       bank_we;

        // banks below the start phase hold the bytes of the next row
        assign rd_row  = (2'(b) < phase) ? base_row + lsbr_pkg::ROW_W'(1) : base_row;
        assign bank_we = req.wr_en && (wr_idx[1:0] == 2'(b));

        lsbr_ram #(
            .WIDTH (lsbr_pkg::BYTE_W),
            .DEPTH (lsbr_pkg::BANK_ROWS)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (bank_we),
            .wr_addr (wr_idx[lsbr_pkg::ROW_W+1:2]),
            .wr_data (req.wr_data),
            .rd_en   (req.rd_en),
            .rd_addr (rd_row),
            .rd_data (rd_data[b])
        );
    end

    // little-endian assembly, lane i comes from bank (phase + i) mod 4
    always_comb begin
        logic [1:0] sel;
        for (int i = 0; i < lsbr_pkg::NUM_BANKS; i++) begin
            sel = phase_reg + 2'(i);
            word[i*lsbr_pkg::BYTE_W +: lsbr_pkg::BYTE_W] =
                lane_valid_reg[i] ? rd_data[sel] : '0;
        end
    end

endmodule

// ===== design/lsb_first_bit_reader.sv =====
// lsb_first_bit_reader: top level, command decode, read position state and result register.
// Depends on lsbr_pkg and lsbr_banks.

// The block reads fields LSB-first out of a little-endian byte buffer of
// lsbr_pkg::BUFFER_DEPTH bytes held in four interleaved byte-wide RAM banks.
// One s_ beat is one command; every command yields exactly one m_ beat carrying
// the read bits (zero unless peek/extract), the byte position and the bit offset
// after the command. Write, restart, align and unknown codes are answered from
// the idle state. Peek and extract pass through a read state: the four banks are
// read in parallel at the current byte position, and the registered RAM data is
// masked and shifted in the next cycle. A new command is taken as soon as the
// previous result has been loaded into the output register, also while that
// result still waits for m_ready, as long as it leaves this cycle. Bytes at or
// past data_length (cfg_wr_en / cfg_wr_data) read as zero; the byte position
// saturates at 65535. A bit_count above 32 acts as 32. No clearing pass after
// reset; bytes must be written before they are read.

module lsb_first_bit_reader (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  lsbr_pkg::in_beat_t          s_data,

    output logic                        m_valid,
    input  logic                        m_ready,
    output lsbr_pkg::out_beat_t         m_data,

    input  logic                        cfg_wr_en,
    input  logic [lsbr_pkg::LEN_W-1:0]  cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    logic [lsbr_pkg::LEN_W-1:0]         data_length_reg;
    logic [lsbr_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [lsbr_pkg::OFF_W-1:0]         off_reg, off_next;
    logic                               extract_reg, extract_next;
    logic [lsbr_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic                               m_valid_reg, m_valid_next;
    lsbr_pkg::out_beat_t                out_reg, out_next;

    logic                               accept;
    logic [lsbr_pkg::COUNT_W-1:0]       count_clamped;
    lsbr_pkg::bank_req_t                bank_req;
    logic [lsbr_pkg::WORD_W-1:0]        word;
    logic [lsbr_pkg::WORD_W-1:0]        mask;
    logic [lsbr_pkg::WORD_W-1:0]        read_bits;
    logic [lsbr_pkg::COUNT_W-1:0]       total;
    logic [lsbr_pkg::POS_W:0]           adv_sum;
    logic [lsbr_pkg::POS_W-1:0]         adv_pos;
    logic [lsbr_pkg::POS_W:0]           inc_sum;
    logic [lsbr_pkg::POS_W-1:0]         inc_pos;

    // one command in flight; the output slot must be free or freeing now
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign count_clamped = (s_data.bit_count > lsbr_pkg::FULL_COUNT) ?
                           lsbr_pkg::FULL_COUNT : s_data.bit_count;

    // bank requests go out at accept time, reads use the current position
    always_comb begin
        bank_req         = '0;
        bank_req.rd_pos  = pos_reg;
        bank_req.wr_addr = s_data.address;
        bank_req.wr_data = s_data.byte_value;
        if (accept) begin
            bank_req.wr_en = (s_data.command == lsbr_pkg::CMD_WRITE);
            bank_req.rd_en = (s_data.command == lsbr_pkg::CMD_EXTRACT) ||
                             (s_data.command == lsbr_pkg::CMD_PEEK);
        end
    end

    lsbr_banks u_banks (
        .aclk        (aclk),
        .req         (bank_req),
        .data_length (data_length_reg),
        .word        (word)
    );

    // mask then shift equals shift then mask: the top off bits are zero anyway
    assign mask      = (count_reg == lsbr_pkg::FULL_COUNT) ? '1 :
                       ((lsbr_pkg::WORD_W'(1) << count_reg) - lsbr_pkg::WORD_W'(1));
    assign read_bits = (word >> off_reg) & mask;

    assign total   = lsbr_pkg::COUNT_W'(off_reg) + count_reg;
    assign adv_sum = {1'b0, pos_reg} + (lsbr_pkg::POS_W+1)'(total[lsbr_pkg::COUNT_W-1:3]);
    assign adv_pos = adv_sum[lsbr_pkg::POS_W] ? lsbr_pkg::POS_MAX
                                               : adv_sum[lsbr_pkg::POS_W-1:0];
    assign inc_sum = {1'b0, pos_reg} + (lsbr_pkg::POS_W+1)'(1);
    assign inc_pos = inc_sum[lsbr_pkg::POS_W] ? lsbr_pkg::POS_MAX
                                               : inc_sum[lsbr_pkg::POS_W-1:0];

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        extract_next = extract_reg;
        count_next   = count_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    extract_next = (s_data.command == lsbr_pkg::CMD_EXTRACT);
                    count_next   = count_clamped;
                    out_next     = '{bits: '0, position: pos_reg, bit_offset: off_reg};
                    m_valid_next = 1'b1;
                    unique case (s_data.command)
                        lsbr_pkg::CMD_RESTART: begin
                            pos_next = '0;
                            off_next = '0;
                            out_next = '{bits: '0, position: '0, bit_offset: '0};
                        end
                        lsbr_pkg::CMD_EXTRACT, lsbr_pkg::CMD_PEEK: begin
                            state_next   = ST_READ;
                            m_valid_next = 1'b0;
                        end
                        lsbr_pkg::CMD_ALIGN: begin
                            if (off_reg != '0) begin
                                pos_next = inc_pos;
                                off_next = '0;
                                out_next = '{bits: '0, position: inc_pos, bit_offset: '0};
                            end
                        end
                        default: begin
                            // byte writes and unknown codes leave the position alone
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                if (extract_reg) begin
                    pos_next = adv_pos;
                    off_next = total[lsbr_pkg::OFF_W-1:0];
                    out_next = '{bits: read_bits, position: adv_pos,
                                 bit_offset: total[lsbr_pkg::OFF_W-1:0]};
                end else begin
                    out_next = '{bits: read_bits, position: pos_reg, bit_offset: off_reg};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            data_length_reg <= '0;
            pos_reg         <= '0;
            off_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            off_reg     <= off_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                data_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        extract_reg <= extract_next;
        count_reg   <= count_next;
        out_reg     <= out_next;
    end

    // while a read waits on the banks, the output slot is empty
    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !m_valid_reg)
        else $error("read in flight with a pending result");

    // an accepted peek or extract always occupies the next cycle
    a_read_takes_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((s_data.command == lsbr_pkg::CMD_EXTRACT) ||
                    (s_data.command == lsbr_pkg::CMD_PEEK)))
        |=> ((state_reg == ST_READ) && !s_ready))
        else $error("peek or extract did not enter the read state");

    // a pending result always reports the current read position
    a_result_tracks_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((out_reg.position == pos_reg) && (out_reg.bit_offset == off_reg)))
        else $error("result position differs from the reader state");

    // align leaves the reader on a byte boundary
    a_align_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.command == lsbr_pkg::CMD_ALIGN)) |=> (off_reg == '0))
        else $error("align left a nonzero bit offset");

endmodule
